// ===== rtl/pstr_pkg.sv =====
// Shared types, constants and helper functions for the packet steering rule table.
package pstr_pkg;

    localparam int RULE_SLOTS_DEF = 16;
    localparam int RULE_W         = 176;

    typedef enum logic [1:0] {
        OP_CLASSIFY = 2'd0,
        OP_ADD      = 2'd1,
        OP_DELETE   = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_PARAM    = 3'd2,
        ST_DUP      = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LOCAL = 2'd1,
        DIR_HOST  = 2'd2,
        DIR_BOTH  = 2'd3
    } dir_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    localparam logic [15:0] ET_PAE  = 16'h888E;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;
    localparam logic [15:0] ET_ARP  = 16'h0806;
    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [7:0]  PR_ICMP = 8'd1;
    localparam logic [7:0]  PR_IGMP = 8'd2;
    localparam logic [7:0]  PR_TCP  = 8'd6;
    localparam logic [7:0]  PR_UDP  = 8'd17;

    localparam logic [1:0] REG_CARRIER = 2'd0;
    localparam logic [1:0] REG_DEFAULT = 2'd1;
    localparam logic [1:0] REG_FORCED  = 2'd2;

    // rule word: addr[47:0], lports[95:48], rports[143:96], ctl[175:144]
    typedef struct packed {
        logic [31:0] ctl;
        logic [47:0] rports;
        logic [47:0] lports;
        logic [47:0] addr;
    } rule_t;

    function automatic logic [1:0] fix_dir(input logic [1:0] d);
        return (d == DIR_LOCAL || d == DIR_HOST) ? d : DIR_BOTH;
    endfunction

    function automatic logic ports_ok(input logic [47:0] p, input logic pb,
                                      input logic rb);
        return !((pb && p[15:0] == 16'd0) || (rb && p[31:16] >= p[47:32]));
    endfunction

    function automatic logic port_check(input logic [47:0] p, input logic rb,
                                        input logic [15:0] fp);
        return (p[15:0] == fp) || (rb && p[31:16] <= fp && fp <= p[47:32]);
    endfunction

endpackage

// ===== rtl/pstr_ram.sv =====
// Generic single-port-write, single-read synchronous RAM.
module pstr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/pstr_match.sv =====
// Rule compare: classify match and exact-copy check for one stored rule.
module pstr_match
    import pstr_pkg::*;
(
    input  rule_t       rule,
    input  rule_t       key,
    output logic        hit,
    output logic        same
);
    logic [5:0] m;
    logic       l4;
    logic [7:0] proto;

    always_comb
    begin
        m     = rule.ctl[5:0];
        proto = key.ctl[13:6];
        l4    = (proto == PR_TCP) || (proto == PR_UDP);
        hit   = 1'b1;
        if (m[0] && rule.addr[31:0] != key.addr[31:0])
        begin
            hit = 1'b0;
        end
        if (m[1] && rule.ctl[13:6] != proto)
        begin
            hit = 1'b0;
        end
        if ((m[2] || m[3]) && !(l4 && port_check(rule.lports, m[3], key.lports[15:0])))
        begin
            hit = 1'b0;
        end
        if ((m[4] || m[5]) && !(l4 && port_check(rule.rports, m[5], key.rports[15:0])))
        begin
            hit = 1'b0;
        end
        same = (rule.addr[31:0] == key.addr[31:0]) && (rule.lports == key.lports)
            && (rule.rports == key.rports) && (rule.ctl[15:0] == key.ctl[15:0]);
    end
endmodule

// ===== rtl/packet_steering_rule_table.sv =====
// Packet steering rule table: top level with sequencer and rule memory.
// An item is taken when start is high and busy low; busy then stays high and
// the one-cycle result strobe done comes in the same cycle that busy falls.
// Results cannot be stalled. The rule memory has one registered read port,
// so a rule walk reads one entry per cycle. Items that need no walk are
// clear, a classify that is not plain IPv4 (or with carrier off or a forced
// direction), an add to a full table and an add or delete with bad rule
// parameters. A classify walk stops at the first hit, an add walk at a
// duplicate; on a miss either walks all used rules, as does a delete that
// finds nothing. A delete that removes rule k moves each later rule down.
module packet_steering_rule_table
    import pstr_pkg::*;
#(
    parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [15:0] eth_type,
    input  logic [7:0]  ip_proto,
    input  logic [31:0] ip_address,
    input  logic [15:0] rmt_port,
    input  logic [15:0] lcl_port,
    input  logic [5:0]  field_mask,
    input  logic [15:0] local_min,
    input  logic [15:0] local_max,
    input  logic [15:0] remote_min,
    input  logic [15:0] remote_max,
    input  logic [1:0]  rule_direction,
    output logic        done,
    output logic [2:0]  status,
    output logic [1:0]  direction,
    output logic [4:0]  hit_index,
    output logic [4:0]  rule_count
);
    localparam int AW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CW = $clog2(RULE_SLOTS + 1);

    state_t state_reg, state_next;
    logic           carrier_reg;
    logic [1:0]     def_reg, forced_reg;
    logic [CW-1:0]  used_reg, used_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic           rvalid_reg, rvalid_next;
    op_t            op_reg;
    logic [15:0]    et_reg;
    rule_t          key_reg;
    logic [2:0]     st_reg, st_next;
    logic [1:0]     dir_reg, dir_next;
    logic [CW-1:0]  hit_reg, hit_next;
    logic           done_reg;
    logic [2:0]     st_q;
    logic [1:0]     dir_q;
    logic [4:0]     hit_q, cnt_q;

    logic           we;
    logic [AW-1:0]  waddr, raddr;
    rule_t          wdata, rdata;
    logic           m_hit, m_same;
    logic           wr_cfg;
    logic           scan_item;
    logic           pok;

    assign pready = 1'b1;
    assign wr_cfg = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg <= 1'b0;
            def_reg     <= DIR_LOCAL;
            forced_reg  <= DIR_NONE;
        end
        else if (wr_cfg)
        begin
            unique case (paddr[3:2])
                REG_CARRIER: carrier_reg <= pwdata[0];
                REG_DEFAULT: def_reg     <= pwdata[1:0];
                REG_FORCED:  forced_reg  <= pwdata[1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CARRIER: prdata = {31'd0, carrier_reg};
            REG_DEFAULT: prdata = {30'd0, def_reg};
            REG_FORCED:  prdata = {30'd0, forced_reg};
            default:     prdata = 32'd0;
        endcase
    end

    pstr_ram #(.WIDTH(RULE_W), .DEPTH(RULE_SLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    pstr_match u_match (
        .rule (rdata),
        .key  (key_reg),
        .hit  (m_hit),
        .same (m_same)
    );

    assign pok = ports_ok(key_reg.lports, key_reg.ctl[2], key_reg.ctl[3])
              && ports_ok(key_reg.rports, key_reg.ctl[4], key_reg.ctl[5]);

    // classify needing a rule walk: carrier on, no force, plain IPv4
    assign scan_item = carrier_reg && forced_reg == DIR_NONE && et_reg == ET_IPV4
        && key_reg.ctl[13:6] != PR_ICMP && key_reg.ctl[13:6] != PR_IGMP;

    // the entry being read in scan is idx_reg - 1 (rvalid marks it)
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        rvalid_next = 1'b0;
        used_next   = used_reg;
        st_next     = st_reg;
        dir_next    = dir_reg;
        hit_next    = hit_reg;
        we          = 1'b0;
        waddr       = idx_reg[AW-1:0];
        wdata       = key_reg;
        raddr       = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    idx_next   = '0;
                end
            end
            S_SCAN:
            begin
                unique case (op_reg)
                    OP_CLASSIFY:
                    begin
                        if (!carrier_reg)
                        begin
                            dir_next = DIR_LOCAL;
                            state_next = S_DONE;
                        end
                        else if (forced_reg != DIR_NONE)
                        begin
                            dir_next = forced_reg;
                            state_next = S_DONE;
                        end
                        else if (et_reg == ET_PAE || et_reg == ET_IPV6)
                        begin
                            dir_next = DIR_LOCAL;
                            state_next = S_DONE;
                        end
                        else if (et_reg == ET_ARP || (et_reg == ET_IPV4 && !scan_item))
                        begin
                            dir_next = DIR_BOTH;
                            state_next = S_DONE;
                        end
                        else if (!scan_item)
                        begin
                            dir_next = DIR_LOCAL;
                            state_next = S_DONE;
                        end
                        else if (rvalid_reg && m_hit)
                        begin
                            dir_next   = fix_dir(rdata.ctl[15:14]);
                            hit_next   = idx_reg - CW'(1);
                            state_next = S_DONE;
                        end
                        else if (idx_reg >= used_reg)
                        begin
                            dir_next   = fix_dir(def_reg);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next    = idx_reg + CW'(1);
                            rvalid_next = 1'b1;
                        end
                    end
                    OP_ADD:
                    begin
                        if (used_reg >= CW'(RULE_SLOTS))
                        begin
                            st_next = ST_FULL;
                            state_next = S_DONE;
                        end
                        else if (!pok)
                        begin
                            st_next = ST_PARAM;
                            state_next = S_DONE;
                        end
                        else if (rvalid_reg && m_same)
                        begin
                            st_next = ST_DUP;
                            state_next = S_DONE;
                        end
                        else if (idx_reg >= used_reg)
                        begin
                            we         = 1'b1;
                            waddr      = used_reg[AW-1:0];
                            used_next  = used_reg + CW'(1);
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next    = idx_reg + CW'(1);
                            rvalid_next = 1'b1;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!pok)
                        begin
                            st_next = ST_PARAM;
                            state_next = S_DONE;
                        end
                        else if (rvalid_reg && m_same)
                        begin
                            // idx_reg now names the next entry to move down
                            st_next    = ST_OK;
                            state_next = S_SHIFT_RD;
                        end
                        else if (idx_reg >= used_reg)
                        begin
                            st_next = ST_NOTFOUND;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            idx_next    = idx_reg + CW'(1);
                            rvalid_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        used_next  = '0;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                if (idx_reg >= used_reg)
                begin
                    used_next  = used_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                we         = 1'b1;
                waddr      = AW'(idx_reg - CW'(1));
                wdata      = rdata;
                idx_next   = idx_reg + CW'(1);
                raddr      = AW'(idx_reg + CW'(1));
                state_next = S_SHIFT_RD;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            idx_reg    <= '0;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            idx_reg    <= idx_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= (state_reg == S_DONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            op_reg                  <= op_t'(operation);
            et_reg                  <= eth_type;
            key_reg.addr            <= {16'd0, ip_address};
            key_reg.lports          <= {local_max, local_min, lcl_port};
            key_reg.rports          <= {remote_max, remote_min, rmt_port};
            key_reg.ctl             <= {16'd0, rule_direction, ip_proto, field_mask};
            st_reg                  <= ST_OK;
            dir_reg                 <= DIR_NONE;
            hit_reg                 <= CW'(RULE_SLOTS);
        end
        else
        begin
            st_reg  <= st_next;
            dir_reg <= dir_next;
            hit_reg <= hit_next;
        end
        if (state_reg == S_DONE)
        begin
            st_q  <= st_reg;
            dir_q <= dir_reg;
            hit_q <= 5'(hit_reg);
            cnt_q <= 5'(used_reg);
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = st_q;
    assign direction  = dir_q;
    assign hit_index  = hit_q;
    assign rule_count = cnt_q;
endmodule

// ===== rtl/pstr_checker.sv =====
// Port-level checker for the packet steering rule table, with its bind.
module pstr_checker
    import pstr_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] status,
    input logic [1:0] direction,
    input logic [4:0] hit_index,
    input logic [4:0] rule_count
);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted item did not raise busy");
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("busy held with result");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rule_count <= 5'd16) else $error("rule count out of range");
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> hit_index <= 5'd16) else $error("hit index out of range");
    a_dir_status: assert property (@(posedge clk) disable iff (!rst_n)
        done && direction != DIR_NONE |-> status == ST_OK)
        else $error("classify with nonzero status");
endmodule

bind packet_steering_rule_table pstr_checker u_pstr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .status     (status),
    .direction  (direction),
    .hit_index  (hit_index),
    .rule_count (rule_count)
);
